/* rtl/two_axis_stepper_move_sequencer_macros.svh */
// Assertion macros shared by the move sequencer RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TWO_AXIS_STEPPER_MOVE_SEQUENCER_MACROS_SVH
`define TWO_AXIS_STEPPER_MOVE_SEQUENCER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define TASMS_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define TASMS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* rtl/tasms_pkg.sv */
// Types, constants and helper functions for the two-axis move sequencer.
// No dependencies; used by tasms_core and the top level.
package tasms_pkg;

    localparam int POS_W      = 8;
    localparam int STEPS_W    = 12;
    localparam int SPM_W      = 4;
    localparam int REQ_W      = 2;
    localparam int COIL_W     = 4;
    localparam int COIL_IDX_W = 3;
    localparam int COIL_DEPTH = 8;

    localparam int PHASE_COUNT_DEF   = 8;
    localparam logic [SPM_W-1:0] SPM_RESET = 4'd5;

    // Request codes; the unused code behaves as a tick.
    localparam logic [REQ_W-1:0] REQ_GOTO = 2'd1;
    localparam logic [REQ_W-1:0] REQ_HOME = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_LEG1 = 2'd1,
        ST_LEG2 = 2'd2
    } t_stage;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [POS_W-1:0]   pend_x;
        logic [POS_W-1:0]   pend_y;
        logic [STEPS_W-1:0] steps_left;
        t_stage             stage;
        logic               step_up;
        logic               active_axis;
        logic               order_home;
    } t_seq_state;

    typedef struct packed {
        logic              step_valid;
        logic              axis_sel;
        logic [COIL_W-1:0] coil_pattern;
        logic              move_done;
        logic              cmd_accepted;
        logic              busy_res;
    } t_result;

    // Half-step coil table.
    function automatic logic [COIL_W-1:0] f_coil(input logic [COIL_IDX_W-1:0] idx);
        logic [COIL_W-1:0] pat;
        case (idx)
            3'd0:    pat = 4'hE;
            3'd1:    pat = 4'hC;
            3'd2:    pat = 4'hD;
            3'd3:    pat = 4'h9;
            3'd4:    pat = 4'hB;
            3'd5:    pat = 4'h3;
            3'd6:    pat = 4'h7;
            3'd7:    pat = 4'h6;
            default: pat = 4'hE;
        endcase
        return pat;
    endfunction

    // Load one leg: distance times step ratio, direction, and commit the target position.
    function automatic t_seq_state f_load_leg(input t_seq_state s, input logic axis,
                                              input logic [SPM_W-1:0] spm);
        t_seq_state         r;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   tgt;
        logic [POS_W-1:0]   span;
        r   = s;
        pos = axis ? s.pos_x  : s.pos_y;
        tgt = axis ? s.pend_x : s.pend_y;
        if (pos < tgt) begin
            span      = tgt - pos;
            r.step_up = 1'b1;
        end else begin
            span      = pos - tgt;
            r.step_up = 1'b0;
        end
        r.steps_left = STEPS_W'(span) * STEPS_W'(spm);
        if (axis) begin
            r.pos_x = tgt;
        end else begin
            r.pos_y = tgt;
        end
        r.active_axis = axis;
        return r;
    endfunction

    // Start the second leg; drop to idle if it has no steps.
    function automatic t_seq_state f_second_leg(input t_seq_state s,
                                                input logic [SPM_W-1:0] spm);
        t_seq_state r;
        r       = s;
        r.stage = ST_LEG2;
        r       = f_load_leg(r, ~s.order_home, spm);
        if (r.steps_left == '0) begin
            r.stage = ST_IDLE;
        end
        return r;
    endfunction

endpackage

/* rtl/tasms_core.sv */
// Per-item sequencer logic: next move state, next phase index and the result item.
// Depends on tasms_pkg.
module tasms_core #(
    parameter int PHASE_COUNT = tasms_pkg::PHASE_COUNT_DEF,
    parameter int PHASE_W     = $clog2(PHASE_COUNT)
) (
    input  tasms_pkg::t_seq_state          i_st,
    input  logic [PHASE_W-1:0]             i_phase,
    input  logic [tasms_pkg::SPM_W-1:0]    i_spm,
    input  logic [tasms_pkg::REQ_W-1:0]    i_req,
    input  logic [tasms_pkg::POS_W-1:0]    i_tgt_x,
    input  logic [tasms_pkg::POS_W-1:0]    i_tgt_y,
    output tasms_pkg::t_seq_state          o_st,
    output logic [PHASE_W-1:0]             o_phase,
    output tasms_pkg::t_result             o_res
);
    import tasms_pkg::*;

    localparam logic [PHASE_W-1:0] PHASE_MAX = PHASE_W'(PHASE_COUNT - 1);

    logic busy;
    logic is_cmd;

    assign busy   = (i_st.stage != ST_IDLE);
    assign is_cmd = (i_req inside {REQ_GOTO, REQ_HOME});

    // Next state
    always_comb begin
        o_st    = i_st;
        o_phase = i_phase;
        if (is_cmd) begin
            if (!busy) begin
                if (i_req == REQ_GOTO) begin
                    o_st.pend_x     = i_tgt_x;
                    o_st.pend_y     = i_tgt_y;
                    o_st.order_home = 1'b0;
                end else begin
                    o_st.pend_x     = '0;
                    o_st.pend_y     = '0;
                    o_st.order_home = 1'b1;
                end
                o_st.stage = ST_LEG1;
                // home drives X first, goto drives Y first
                o_st = f_load_leg(o_st, o_st.order_home, i_spm);
                if (o_st.steps_left == '0) begin
                    o_st = f_second_leg(o_st, i_spm);
                end
            end
        end else if (busy) begin
            if (i_st.step_up) begin
                o_phase = (i_phase == '0) ? PHASE_MAX : i_phase - 1'b1;
            end else begin
                o_phase = (i_phase == PHASE_MAX) ? '0 : i_phase + 1'b1;
            end
            if (o_st.steps_left != '0) begin
                o_st.steps_left = o_st.steps_left - 1'b1;
            end
            if (o_st.steps_left == '0) begin
                if (i_st.stage == ST_LEG1) begin
                    o_st = f_second_leg(o_st, i_spm);
                end else begin
                    o_st.stage = ST_IDLE;
                end
            end
        end
    end

    // Result item
    always_comb begin
        o_res              = '0;
        o_res.cmd_accepted = is_cmd && !busy;
        o_res.busy_res     = (o_st.stage != ST_IDLE);
        if (!is_cmd && busy) begin
            o_res.step_valid   = 1'b1;
            o_res.axis_sel     = i_st.active_axis;
            o_res.coil_pattern = f_coil(COIL_IDX_W'(i_phase));
            o_res.move_done    = (o_st.stage == ST_IDLE);
        end
    end

endmodule

/* rtl/two_axis_stepper_move_sequencer.sv */
// Top level of the two-axis stepper move sequencer: input register, sequencer
// logic (tasms_core) and output register. Depends on tasms_pkg and the macro header.
//
// Usage:
//   Input stream s_axis_*: one request per transfer. tuser carries the request
//   kind (tick, goto, home); tdata carries target X (low byte) and Y (high byte).
//   Output stream m_axis_*: exactly one result per request, in order. tuser is
//   the axis select; tdata holds step valid, coil pattern, move done, command
//   accepted and busy flags.
//   i_cfg_we / i_cfg_wdata write the steps-per-mm ratio; write only while idle.
// Timing:
//   A request taken at one edge lands in the input register, is evaluated there and
//   moves on to the output register, which drives m_axis. One request per
//   cycle is sustained: the input register advances whenever the output
//   register is empty or is being read in the same cycle.
//   When the receiver stalls, the output register holds, the input register
//   fills, and then s_axis_tready drops until the output is taken.
// Reset (synchronous, active low): both registers empty, positions and phase
//   zero, no move in progress, steps-per-mm back to 5.
`include "two_axis_stepper_move_sequencer_macros.svh"

module two_axis_stepper_move_sequencer #(
    parameter int PHASE_COUNT = tasms_pkg::PHASE_COUNT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tasms_pkg::SPM_W-1:0] i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [15:0]                 s_axis_tdata,   // [7:0] target_x, [15:8] target_y
    input  logic [1:0]                  s_axis_tuser,   // [1:0] req_type
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // [0] step_valid, [4:1] coil_pattern, [5] move_done, [6] cmd_accepted, [7] busy_res
    output logic [7:0]                  m_axis_tdata,
    output logic [0:0]                  m_axis_tuser    // [0] axis_sel
);
    import tasms_pkg::*;

    localparam int PHASE_W = $clog2(PHASE_COUNT);

    logic                 r_in_valid;
    logic [REQ_W-1:0]     r_in_req;
    logic [POS_W-1:0]     r_in_x;
    logic [POS_W-1:0]     r_in_y;

    t_seq_state           r_st;
    t_seq_state           n_st;
    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   n_phase;
    logic [SPM_W-1:0]     r_spm;

    logic                 r_out_valid;
    t_result              r_out;
    t_result              n_out;

    logic                 advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    tasms_core #(
        .PHASE_COUNT (PHASE_COUNT),
        .PHASE_W     (PHASE_W)
    ) u_core (
        .i_st    (r_st),
        .i_phase (r_phase),
        .i_spm   (r_spm),
        .i_req   (r_in_req),
        .i_tgt_x (r_in_x),
        .i_tgt_y (r_in_y),
        .o_st    (n_st),
        .o_phase (n_phase),
        .o_res   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm <= SPM_RESET;
        end else if (i_cfg_we) begin
            r_spm <= i_cfg_wdata;
        end
    end

    // Input register: refill on every transfer, empty once its item moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_req <= s_axis_tuser;
            r_in_x   <= s_axis_tdata[7:0];
            r_in_y   <= s_axis_tdata[15:8];
        end
    end

    // Move state commits only when the item's result is captured.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= '{stage: ST_IDLE, default: '0};
            r_phase <= '0;
        end else if (advance) begin
            r_st    <= n_st;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid   = r_out_valid;
    assign m_axis_tuser[0] = r_out.axis_sel;
    assign m_axis_tdata    = {r_out.busy_res, r_out.cmd_accepted, r_out.move_done,
                              r_out.coil_pattern, r_out.step_valid};

    `TASMS_ASSERT_IMPL(a_busy_has_steps, r_st.stage != ST_IDLE, r_st.steps_left != '0,
        "move in progress with no steps left")
    `TASMS_ASSERT_ALWAYS(a_phase_range, r_phase <= PHASE_W'(PHASE_COUNT - 1),
        "phase index out of range")
    `TASMS_ASSERT_IMPL(a_step_not_cmd, r_out_valid, !(r_out.step_valid && r_out.cmd_accepted),
        "result both steps and accepts a command")
    `TASMS_ASSERT_IMPL(a_done_ends_move, r_out_valid && r_out.move_done,
        r_out.step_valid && !r_out.busy_res, "move done while still busy or without a step")
    `TASMS_ASSERT_IMPL(a_stall_cause, !s_axis_tready, r_out_valid && !m_axis_tready,
        "input stalled while output is free")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for two_axis_stepper_move_sequencer: random and directed
// requests on s_axis, each m_axis result checked against an in-line move predictor.
// Depends on tasms_pkg and the top-level RTL.

module tb;
    import tasms_pkg::*;

    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;
    localparam int PHASES       = 8;
    localparam int REPORT_LIMIT = 10;

    // Tracks the sequencer's move state and holds the results it should produce.
    class step_scoreboard;
        t_result              expected_steps[$];
        int unsigned          mismatches;
        logic [SPM_W-1:0]     spm;
        logic [POS_W-1:0]     pos_x, pos_y, pend_x, pend_y;
        logic [2:0]           phase;
        logic [STEPS_W-1:0]   left;
        t_stage               stage;
        logic                 going_up, axis_now, homing;

        function new();
            mismatches = 0;
            spm        = SPM_RESET;
            pos_x      = '0;
            pos_y      = '0;
            pend_x     = '0;
            pend_y     = '0;
            phase      = '0;
            left       = '0;
            stage      = ST_IDLE;
            going_up   = 1'b0;
            axis_now   = 1'b0;
            homing     = 1'b0;
        endfunction

        function bit busy();
            return stage != ST_IDLE;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        function logic [COIL_W-1:0] coil_at(logic [2:0] idx);
            case (idx)
                3'd0: return 4'hE;
                3'd1: return 4'hC;
                3'd2: return 4'hD;
                3'd3: return 4'h9;
                3'd4: return 4'hB;
                3'd5: return 4'h3;
                3'd6: return 4'h7;
                default: return 4'h6;
            endcase
        endfunction

        // Commit the target of one axis and load its step count.
        function void start_leg(logic axis);
            logic [POS_W-1:0] from, to, span;
            from     = axis ? pos_x : pos_y;
            to       = axis ? pend_x : pend_y;
            going_up = from < to;
            span     = going_up ? to - from : from - to;
            left     = STEPS_W'(span) * STEPS_W'(spm);
            if (axis) begin
                pos_x = to;
            end else begin
                pos_y = to;
            end
            axis_now = axis;
        endfunction

        function void next_leg();
            stage = ST_LEG2;
            start_leg(!homing);
            if (left == '0) begin
                stage = ST_IDLE;
            end
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] tx,
                                   logic [POS_W-1:0] ty);
            t_result r;
            bit      was_busy;
            r        = '0;
            was_busy = busy();
            if (req == REQ_GOTO || req == REQ_HOME) begin
                if (!was_busy) begin
                    r.cmd_accepted = 1'b1;
                    homing = (req == REQ_HOME);
                    pend_x = homing ? '0 : tx;
                    pend_y = homing ? '0 : ty;
                    stage  = ST_LEG1;
                    start_leg(homing);
                    if (left == '0) begin
                        next_leg();
                    end
                end
            end else if (was_busy) begin
                r.step_valid   = 1'b1;
                r.axis_sel     = axis_now;
                r.coil_pattern = coil_at(phase);
                if (going_up) begin
                    phase = (phase == 0) ? 3'(PHASES - 1) : 3'(phase - 1);
                end else begin
                    phase = (int'(phase) + 1 >= PHASES) ? 3'd0 : 3'(phase + 1);
                end
                if (left != '0) begin
                    left = left - 1'b1;
                end
                if (left == '0) begin
                    if (stage == ST_LEG1) begin
                        next_leg();
                    end else begin
                        stage = ST_IDLE;
                    end
                    r.move_done = (stage == ST_IDLE);
                end
            end
            r.busy_res = busy();
            expected_steps.push_back(r);
        endfunction

        function void match_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t mismatch on %s: expected %0h, got %0h",
                             $realtime, field, want, got);
                end
            end
        endfunction

        function void check_result(logic [7:0] data, logic axis);
            t_result want;
            if (expected_steps.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t unexpected result: tdata %0h tuser %0h",
                             $realtime, data, axis);
                end
                return;
            end
            want = expected_steps.pop_front();
            match_field("step_valid", want.step_valid, data[0]);
            match_field("coil_pattern", want.coil_pattern, data[4:1]);
            match_field("move_done", want.move_done, data[5]);
            match_field("cmd_accepted", want.cmd_accepted, data[6]);
            match_field("busy_res", want.busy_res, data[7]);
            match_field("axis_sel", want.axis_sel, axis);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [SPM_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata  = '0;   // [7:0] target_x, [15:8] target_y
    logic [1:0]        s_axis_tuser  = '0;   // [1:0] req_type
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // [0] step_valid, [4:1] coil_pattern, [5] move_done, [6] cmd_accepted, [7] busy_res
    logic [7:0]        m_axis_tdata;
    logic [0:0]        m_axis_tuser;         // [0] axis_sel

    bit                calm = 1'b0;
    step_scoreboard    sb   = new();

    two_axis_stepper_move_sequencer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL two_axis_stepper_move_sequencer");
        $finish;
    end

    // Receiver: stall in short random bursts, never in the calm stretch.
    initial begin
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(logic [REQ_W-1:0] req, logic [POS_W-1:0] tx,
                             logic [POS_W-1:0] ty);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {ty, tx};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(req, tx, ty);
        @(negedge i_clk);
    endtask

    // Tick until the predicted move is over.
    task automatic finish_move();
        while (sb.busy()) begin
            send_item(($urandom_range(0, 7) == 0) ? REQ_SPARE : REQ_TICK,
                      8'($urandom), 8'($urandom));
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_spm(logic [SPM_W-1:0] v);
        finish_move();
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.spm = v;
    endtask

    // Mostly a few millimetres from the current position, now and then a longer jump.
    function automatic logic [POS_W-1:0] near(logic [POS_W-1:0] pos);
        int v;
        if ($urandom_range(0, 31) == 0) begin
            v = int'(pos) + int'($urandom_range(0, 80)) - 40;
        end else begin
            v = int'(pos) + int'($urandom_range(0, 10)) - 5;
        end
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return 8'(v);
    endfunction

    task automatic random_item();
        logic [REQ_W-1:0] req;
        int unsigned      pick;
        pick = $urandom_range(0, 99);
        if (sb.busy()) begin
            req = (pick < 85) ? REQ_TICK : (pick < 90) ? REQ_SPARE :
                  (pick < 95) ? REQ_GOTO : REQ_HOME;
        end else begin
            req = (pick < 50) ? REQ_GOTO : (pick < 75) ? REQ_HOME :
                  (pick < 90) ? REQ_TICK : REQ_SPARE;
        end
        send_item(req, near(sb.pos_x), near(sb.pos_y));
    endtask

    initial begin
        int spm_plan[5];
        spm_plan = '{1, 15, 0, $urandom_range(2, 14), 5};
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Idle ticks, a move of no steps, then a goto with refused commands mid-move.
        send_item(REQ_TICK, 8'h00, 8'h00);
        send_item(REQ_SPARE, 8'hFF, 8'hFF);
        send_item(REQ_GOTO, 8'h00, 8'h00);
        send_item(REQ_GOTO, 8'h01, 8'h02);
        send_item(REQ_HOME, 8'h00, 8'h00);
        send_item(REQ_GOTO, 8'hFF, 8'hFF);
        send_item(REQ_SPARE, 8'h55, 8'hAA);
        finish_move();

        // Zero ratio: every leg is empty but positions still move.
        write_spm(4'd0);
        send_item(REQ_GOTO, 8'hFF, 8'hFF);
        send_item(REQ_HOME, 8'hFF, 8'hFF);
        send_item(REQ_GOTO, 8'hFF, 8'hFF);
        write_spm(4'd1);
        send_item(REQ_GOTO, 8'hFE, 8'hFE);
        finish_move();
        write_spm(4'd0);
        send_item(REQ_HOME, 8'h00, 8'h00);
        write_spm(4'd2);
        send_item(REQ_GOTO, 8'h01, 8'h03);
        finish_move();
        send_item(REQ_HOME, 8'hFF, 8'h00);
        finish_move();

        foreach (spm_plan[p]) begin
            write_spm(4'(spm_plan[p]));
            if (p == 4) begin
                calm = 1'b1;
            end
            repeat (240) random_item();
        end
        finish_move();

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS two_axis_stepper_move_sequencer");
        end else begin
            $display("FAIL two_axis_stepper_move_sequencer");
        end
        $finish;
    end

endmodule
